/* rtl/core/utf8d_pkg.sv */
package utf8d_pkg;

  // widths of the result fields
  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  // most results one input byte can cause
  localparam int unsigned MaxRes = 4;
  localparam int unsigned NumW   = 3;

  // result queue geometry (depth is a power of two, pointers wrap)
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = 3;
  localparam int unsigned CntW      = 4;

  // replacement answer for any invalid byte
  localparam logic [CpW-1:0] ErrCodepoint = 21'h00003F;

  typedef struct packed {
    logic [CpW-1:0]  codepoint;
    logic [LenW-1:0] byte_count;
    logic            run_last;
  } result_t;

  // all results caused by one byte, slot 0 first
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [NumW-1:0]      num;
  } batch_t;

endpackage

/* rtl/core/utf8d_decode.sv */
module utf8d_decode import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       proc_i,
  input  logic [7:0] byte_i,
  output batch_t     batch_o
);

  // pending sequence state
  logic [7:0]      lead_q, lead_d;
  logic [1:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;

  logic            pend;
  logic            is_cont;
  logic            is_lead;
  logic [LenW-1:0] need;
  logic [CpW-1:0]  cp;
  logic [NumW-1:0] n_err;
  logic            tail_v;
  result_t         tail;
  logic [NumW-1:0] num;

  assign pend    = (cnt_q != 2'd0);
  assign is_cont = (byte_i[7:6] == 2'b10);

  // classify the incoming byte as a lead of a multi-byte form
  always_comb begin
    is_lead = (byte_i inside {[8'hC0:8'hF7]});
  end

  // total length of the pending form, from its lead
  always_comb begin
    if (lead_q[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (lead_q[7:4] == 4'b1110) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
  end

  // codepoint assembly once the last continuation arrives
  always_comb begin
    case (need)
      3'd2:    cp = CpW'({lead_q[4:0], byte_i[5:0]});
      3'd3:    cp = CpW'({lead_q[3:0], held_q[0][5:0], byte_i[5:0]});
      3'd4:    cp = {lead_q[2:0], held_q[0][5:0], held_q[1][5:0], byte_i[5:0]};
      default: cp = ErrCodepoint;
    endcase
  end

  // next state and the result list for this byte
  always_comb begin
    lead_d          = lead_q;
    held_d          = held_q;
    cnt_d           = cnt_q;
    n_err           = '0;
    tail_v          = 1'b0;
    tail.codepoint  = ErrCodepoint;
    tail.byte_count = LenW'(1);
    tail.run_last   = 1'b1;
    if (proc_i) begin
      if (pend && is_cont) begin
        if ({1'b0, cnt_q} + 3'd1 == need) begin
          tail_v          = 1'b1;
          tail.codepoint  = cp;
          tail.byte_count = need;
          cnt_d           = 2'd0;
        end else begin
          held_d[cnt_q[1]] = byte_i;
          cnt_d            = cnt_q + 2'd1;
        end
      end else begin
        // a broken form answers its lead and each held byte with an error
        n_err = pend ? NumW'(cnt_q) : '0;
        cnt_d = 2'd0;
        if (byte_i == 8'h00) begin
          tail_v = 1'b0;
        end else if (!byte_i[7]) begin
          tail_v         = 1'b1;
          tail.codepoint = CpW'(byte_i);
        end else if (is_lead) begin
          lead_d = byte_i;
          cnt_d  = 2'd1;
        end else begin
          tail_v = 1'b1;
        end
      end
    end
  end

  assign num = n_err + NumW'(tail_v);

  // fill the slots: errors first, then the tail result
  always_comb begin
    batch_o.num = num;
    for (int i = 0; i < MaxRes; i++) begin
      if (NumW'(i) < n_err) begin
        batch_o.res[i].codepoint  = ErrCodepoint;
        batch_o.res[i].byte_count = LenW'(1);
      end else begin
        batch_o.res[i].codepoint  = tail.codepoint;
        batch_o.res[i].byte_count = tail.byte_count;
      end
      batch_o.res[i].run_last = (NumW'(i) + NumW'(1) == num);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'h00;
      cnt_q  <= 2'd0;
    end else begin
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
    end
  end

  // held continuations, only read after being written
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

/* rtl/core/utf8d_fifo.sv */
module utf8d_fifo import utf8d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  batch_t  batch_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t head_o
);

  result_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [PtrW-1:0] wr_idx [MaxRes];
  logic            pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && !stall_i;
  assign head_o  = mem_q[rd_ptr_q];

  // room for a full batch of results
  assign room_o = (CntW'(FifoDepth) - count_q) >= CntW'(MaxRes);

  // write addresses of the batch slots
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      wr_idx[i] = wr_ptr_q + PtrW'(i);
    end
  end

  // storage, several writes and one read per cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (NumW'(i) < batch_i.num) begin
        mem_q[wr_idx[i]] <= batch_i.res[i];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(batch_i.num);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(batch_i.num) - CntW'(pop);
    end
  end

endmodule

/* rtl/core/utf8_codepoint_decoder_core.sv */
// channel | direction | handshake           | payload
// in      | sink      | in_valid_i/in_stall_o | in_byte_i
// out     | source    | out_valid_o/out_stall_i | codepoint_o, byte_count_o, run_last_o
//
// one byte is taken per cycle unless the input stalls; it is held in the input register and its
// results are written into an 8-entry result queue, from which results leave one per cycle
// while out_stall_i is low.
// a byte may cause up to four results; the input stalls while a byte waits in
// the input register and the queue has fewer than four free entries.
// reset clears the pending sequence and empties the queue.
module utf8_codepoint_decoder_core import utf8d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CpW-1:0]  codepoint_o,
  output logic [LenW-1:0] byte_count_o,
  output logic            run_last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       room;
  logic       proc;
  logic       accept;
  batch_t     batch;
  result_t    head;

  assign proc       = valid_q && room;
  assign in_stall_o = valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (proc) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  utf8d_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .proc_i  (proc),
    .byte_i  (byte_q),
    .batch_o (batch)
  );

  utf8d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign codepoint_o  = head.codepoint;
  assign byte_count_o = head.byte_count;
  assign run_last_o   = head.run_last;

endmodule

/* rtl/core/utf8d_checker.sv */
module utf8d_checker import utf8d_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CpW-1:0]  codepoint_o,
  input logic [LenW-1:0] byte_count_o,
  input logic            run_last_o
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(codepoint_o)
      && $stable(byte_count_o) && $stable(run_last_o))
    else $error("stalled output transaction changed");

  // codepoint fits the length it claims
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o == 3'd1 && codepoint_o < 21'h80)
      || (byte_count_o == 3'd2 && codepoint_o < 21'h800)
      || (byte_count_o == 3'd3 && codepoint_o < 21'h10000)
      || byte_count_o == 3'd4)
    else $error("codepoint does not match byte count");

  // results of one byte are queued together, so a run never breaks
  a_run_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("gap inside a run of results");

  // the input stalls only while a byte is held, never straight out of reset
  a_stall_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

  // no stall is raised on an idle input without a byte held
  a_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !in_stall_o |=> !in_stall_o)
    else $error("input stalled with no byte held");

endmodule

bind utf8_codepoint_decoder_core utf8d_checker u_checker (.*);
